FILE: hw/rtl/tspm_pkg.sv
// ----------------------------------------------------------------------------
// Two-axis step pulse mover: shared definitions
// Widths, reset values, register indexes, item and result types used by the
// front classifier, the item queue and the pulse sequencer.
// ----------------------------------------------------------------------------
package tspm_pkg;

    localparam int POS_W      = 14;
    localparam int HALF_W     = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [HALF_W-1:0] HALF_X_RESET  = 16'd1000;
    localparam logic [HALF_W-1:0] HALF_Y_RESET  = 16'd2000;
    localparam logic [POS_W-1:0]  MAX_POS_RESET = 14'd5000;

    // Register indexes on the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HALF_X  = 2'd0,
        CFG_HALF_Y  = 2'd1,
        CFG_MAX_POS = 2'd2
    } cfg_index_t;

    // Item class decided at the front
    typedef enum logic [1:0] {
        KIND_TICK  = 2'd0,
        KIND_MOVE  = 2'd1,
        KIND_RANGE = 2'd2
    } item_kind_t;

    // Result status codes
    typedef enum logic [1:0] {
        ST_TICK   = 2'd0,
        ST_ACCEPT = 2'd1,
        ST_RANGE  = 2'd2,
        ST_BUSY   = 2'd3
    } status_t;

    // Move phase, one-hot
    typedef enum logic [4:0] {
        PH_IDLE = 5'b00001,
        PH_XHI  = 5'b00010,
        PH_XLO  = 5'b00100,
        PH_YHI  = 5'b01000,
        PH_YLO  = 5'b10000
    } phase_t;

    typedef struct packed {
        logic [HALF_W-1:0] half_x;
        logic [HALF_W-1:0] half_y;
        logic [POS_W-1:0]  max_pos;
    } cfg_t;

    typedef struct packed {
        item_kind_t       kind;
        logic [POS_W-1:0] target_x;
        logic [POS_W-1:0] target_y;
    } queue_item_t;

    typedef struct packed {
        logic    step_x;
        logic    dir_x;
        logic    step_y;
        logic    dir_y;
        logic    busy;
        status_t status;
    } result_t;

endpackage

FILE: hw/rtl/tspm_front.sv
// ----------------------------------------------------------------------------
// Two-axis step pulse mover: front classifier
// Sorts each incoming beat into a tick, an in-range move or an out-of-range
// move and packs it for the item queue.
// ----------------------------------------------------------------------------
module tspm_front (
    input  logic                      req_type,
    input  logic [tspm_pkg::POS_W-1:0] target_x,
    input  logic [tspm_pkg::POS_W-1:0] target_y,
    input  tspm_pkg::cfg_t            cfg,
    output tspm_pkg::queue_item_t     item
);

    logic out_of_range;

    // Check both targets against the position limit
    assign out_of_range = (target_x > cfg.max_pos) || (target_y > cfg.max_pos);

    // Classify the beat
    always_comb
    begin
        item.target_x = target_x;
        item.target_y = target_y;
        if (!req_type)
        begin
            item.kind = tspm_pkg::KIND_TICK;
        end
        else if (out_of_range)
        begin
            item.kind = tspm_pkg::KIND_RANGE;
        end
        else
        begin
            item.kind = tspm_pkg::KIND_MOVE;
        end
    end

endmodule

FILE: hw/rtl/tspm_queue.sv
// ----------------------------------------------------------------------------
// Two-axis step pulse mover: item queue
// Short FIFO between the classifier and the sequencer so each side can
// stall on its own. Push and pop may happen in the same cycle.
// ----------------------------------------------------------------------------
module tspm_queue #(
    parameter int DEPTH = 2
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push_valid,
    output logic                  push_stall,
    input  tspm_pkg::queue_item_t push_item,
    output logic                  pop_valid,
    input  logic                  pop,
    output tspm_pkg::queue_item_t pop_item
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    tspm_pkg::queue_item_t entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign push_stall = (count_reg == CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_item   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && !push_stall;
    assign do_pop     = pop && pop_valid;

    // Advance pointers and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!do_push && do_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the pushed beat
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

FILE: hw/rtl/tspm_back.sv
// ----------------------------------------------------------------------------
// Two-axis step pulse mover: pulse sequencer
// Carries out one queued item per cycle unless the output stalls: starts
// moves, advances the pulse phase on ticks and registers the output beat.
// ----------------------------------------------------------------------------
module tspm_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  tspm_pkg::cfg_t        cfg,
    input  logic                  item_valid,
    input  tspm_pkg::queue_item_t item,
    output logic                  pop,
    output logic                  res_valid,
    input  logic                  res_stall,
    output tspm_pkg::result_t     res
);

    localparam int POS_W  = tspm_pkg::POS_W;
    localparam int HALF_W = tspm_pkg::HALF_W;

    tspm_pkg::phase_t   phase_reg, phase_next;
    logic [POS_W-1:0]   pos_x_reg, pos_x_next;
    logic [POS_W-1:0]   pos_y_reg, pos_y_next;
    logic [POS_W-1:0]   left_x_reg, left_x_next;
    logic [POS_W-1:0]   left_y_reg, left_y_next;
    logic [HALF_W-1:0]  cnt_reg, cnt_next;
    logic               dir_x_reg, dir_x_next;
    logic               dir_y_reg, dir_y_next;
    logic               out_valid_reg, out_valid_next;
    tspm_pkg::result_t  out_reg, out_next;

    logic [HALF_W:0]    cnt_inc;
    logic               done_x;
    logic               done_y;
    logic [POS_W-1:0]   diff_x;
    logic [POS_W-1:0]   diff_y;
    logic [POS_W-1:0]   left_x_dec;
    logic [POS_W-1:0]   left_y_dec;
    tspm_pkg::phase_t   first_phase;
    tspm_pkg::phase_t   after_x_pulse;
    tspm_pkg::phase_t   after_y_pulse;
    tspm_pkg::status_t  status;
    logic               step_x;
    logic               step_y;

    assign pop       = item_valid && (!out_valid_reg || !res_stall);
    assign res_valid = out_valid_reg;
    assign res       = out_reg;

    // Half-period end: a zero half period ends after one tick as well
    assign cnt_inc = {1'b0, cnt_reg} + 1'b1;
    assign done_x  = (cnt_inc >= {1'b0, cfg.half_x});
    assign done_y  = (cnt_inc >= {1'b0, cfg.half_y});

    // Step distances of a new move
    assign diff_x = (item.target_x > pos_x_reg) ? item.target_x - pos_x_reg
                                                : pos_x_reg - item.target_x;
    assign diff_y = (item.target_y > pos_y_reg) ? item.target_y - pos_y_reg
                                                : pos_y_reg - item.target_y;

    assign left_x_dec = (left_x_reg != '0) ? left_x_reg - 1'b1 : left_x_reg;
    assign left_y_dec = (left_y_reg != '0) ? left_y_reg - 1'b1 : left_y_reg;

    // Pick the next pulse: X pulses first, then Y
    always_comb
    begin
        if (diff_x != '0)
        begin
            first_phase = tspm_pkg::PH_XHI;
        end
        else if (diff_y != '0)
        begin
            first_phase = tspm_pkg::PH_YHI;
        end
        else
        begin
            first_phase = tspm_pkg::PH_IDLE;
        end

        if (left_x_dec != '0)
        begin
            after_x_pulse = tspm_pkg::PH_XHI;
        end
        else if (left_y_reg != '0)
        begin
            after_x_pulse = tspm_pkg::PH_YHI;
        end
        else
        begin
            after_x_pulse = tspm_pkg::PH_IDLE;
        end

        if (left_x_reg != '0)
        begin
            after_y_pulse = tspm_pkg::PH_XHI;
        end
        else if (left_y_dec != '0)
        begin
            after_y_pulse = tspm_pkg::PH_YHI;
        end
        else
        begin
            after_y_pulse = tspm_pkg::PH_IDLE;
        end
    end

    // Execute the item at the queue head
    always_comb
    begin
        phase_next  = phase_reg;
        pos_x_next  = pos_x_reg;
        pos_y_next  = pos_y_reg;
        left_x_next = left_x_reg;
        left_y_next = left_y_reg;
        cnt_next    = cnt_reg;
        dir_x_next  = dir_x_reg;
        dir_y_next  = dir_y_reg;
        status      = tspm_pkg::ST_TICK;

        case (item.kind)
            tspm_pkg::KIND_MOVE:
            begin
                if (phase_reg != tspm_pkg::PH_IDLE)
                begin
                    status = tspm_pkg::ST_BUSY;
                end
                else
                begin
                    status      = tspm_pkg::ST_ACCEPT;
                    dir_x_next  = (item.target_x <= pos_x_reg);
                    dir_y_next  = (item.target_y <= pos_y_reg);
                    left_x_next = diff_x;
                    left_y_next = diff_y;
                    pos_x_next  = item.target_x;
                    pos_y_next  = item.target_y;
                    cnt_next    = '0;
                    phase_next  = first_phase;
                end
            end
            tspm_pkg::KIND_RANGE:
            begin
                status = (phase_reg != tspm_pkg::PH_IDLE) ? tspm_pkg::ST_BUSY
                                                          : tspm_pkg::ST_RANGE;
            end
            default:
            begin
                status = tspm_pkg::ST_TICK;
                case (phase_reg)
                    tspm_pkg::PH_XHI:
                    begin
                        if (done_x)
                        begin
                            cnt_next   = '0;
                            phase_next = tspm_pkg::PH_XLO;
                        end
                        else
                        begin
                            cnt_next = cnt_inc[HALF_W-1:0];
                        end
                    end
                    tspm_pkg::PH_XLO:
                    begin
                        if (done_x)
                        begin
                            cnt_next    = '0;
                            left_x_next = left_x_dec;
                            phase_next  = after_x_pulse;
                        end
                        else
                        begin
                            cnt_next = cnt_inc[HALF_W-1:0];
                        end
                    end
                    tspm_pkg::PH_YHI:
                    begin
                        if (done_y)
                        begin
                            cnt_next   = '0;
                            phase_next = tspm_pkg::PH_YLO;
                        end
                        else
                        begin
                            cnt_next = cnt_inc[HALF_W-1:0];
                        end
                    end
                    tspm_pkg::PH_YLO:
                    begin
                        if (done_y)
                        begin
                            cnt_next    = '0;
                            left_y_next = left_y_dec;
                            phase_next  = after_y_pulse;
                        end
                        else
                        begin
                            cnt_next = cnt_inc[HALF_W-1:0];
                        end
                    end
                    default:
                    begin
                        cnt_next   = '0;
                        phase_next = tspm_pkg::PH_IDLE;
                    end
                endcase
            end
        endcase
    end

    // Step levels: a tick shows the phase it ran in, a move the phase it leads to
    assign step_x = (item.kind == tspm_pkg::KIND_TICK) ? (phase_reg == tspm_pkg::PH_XHI)
                                                       : (phase_next == tspm_pkg::PH_XHI);
    assign step_y = (item.kind == tspm_pkg::KIND_TICK) ? (phase_reg == tspm_pkg::PH_YHI)
                                                       : (phase_next == tspm_pkg::PH_YHI);

    // Load or drain the output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (pop)
        begin
            out_valid_next  = 1'b1;
            out_next.step_x = step_x;
            out_next.dir_x  = dir_x_next;
            out_next.step_y = step_y;
            out_next.dir_y  = dir_y_next;
            out_next.busy   = (phase_next != tspm_pkg::PH_IDLE);
            out_next.status = status;
        end
        else if (out_valid_reg && !res_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= tspm_pkg::PH_IDLE;
            pos_x_reg     <= '0;
            pos_y_reg     <= '0;
            left_x_reg    <= '0;
            left_y_reg    <= '0;
            cnt_reg       <= '0;
            dir_x_reg     <= 1'b0;
            dir_y_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (pop)
            begin
                phase_reg  <= phase_next;
                pos_x_reg  <= pos_x_next;
                pos_y_reg  <= pos_y_next;
                left_x_reg <= left_x_next;
                left_y_reg <= left_y_next;
                cnt_reg    <= cnt_next;
                dir_x_reg  <= dir_x_next;
                dir_y_reg  <= dir_y_next;
            end
        end
    end

    // Hold the result payload
    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

`ifndef NO_ASSERTIONS
    // Idle means no steps pending
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == tspm_pkg::PH_IDLE) |-> (left_x_reg == '0 && left_y_reg == '0))
        else $error("idle with steps pending");

    // Idle keeps the tick counter cleared
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == tspm_pkg::PH_IDLE) |-> (cnt_reg == '0))
        else $error("tick counter not cleared while idle");

    // Y pulses only run once all X pulses are done
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == tspm_pkg::PH_YHI || phase_reg == tspm_pkg::PH_YLO)
        |-> (left_x_reg == '0))
        else $error("Y pulse with X steps pending");

    // Every executed item shows up in the output register
    assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> out_valid_reg)
        else $error("executed item lost");
`endif

endmodule

FILE: hw/rtl/two_axis_step_pulse_mover_top.sv
// Path: an accepted beat is stored in the item queue, then in the output register.
// Throughput: one beat per cycle while the output is not stalled.
// A stalled output fills the item queue (QUEUE_DEPTH beats) before in_stall rises.
// Reset: half periods 1000 and 2000 ticks, position limit 5000, positions and
// step counts zero, sequencer idle, queue and output register empty.
// ----------------------------------------------------------------------------
// Two-axis step pulse mover: top level
// Classifier, item queue and pulse sequencer with the configuration registers.
// ----------------------------------------------------------------------------
module two_axis_step_pulse_mover_top #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [tspm_pkg::CFG_IDX_W-1:0]    cfg_idx,
    input  logic [tspm_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              req_type,
    input  logic [tspm_pkg::POS_W-1:0]        target_x,
    input  logic [tspm_pkg::POS_W-1:0]        target_y,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic                              step_x,
    output logic                              dir_x,
    output logic                              step_y,
    output logic                              dir_y,
    output logic                              busy_res,
    output logic [1:0]                        status
);

    tspm_pkg::cfg_t        cfg_reg;
    tspm_pkg::queue_item_t front_item;
    tspm_pkg::queue_item_t head_item;
    tspm_pkg::result_t     res;
    logic                  head_valid;
    logic                  head_pop;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.half_x  <= tspm_pkg::HALF_X_RESET;
            cfg_reg.half_y  <= tspm_pkg::HALF_Y_RESET;
            cfg_reg.max_pos <= tspm_pkg::MAX_POS_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_idx)
                tspm_pkg::CFG_HALF_X:  cfg_reg.half_x  <= cfg_wdata;
                tspm_pkg::CFG_HALF_Y:  cfg_reg.half_y  <= cfg_wdata;
                tspm_pkg::CFG_MAX_POS: cfg_reg.max_pos <= cfg_wdata[tspm_pkg::POS_W-1:0];
                default:               cfg_reg         <= cfg_reg;
            endcase
        end
    end

    tspm_front u_front (
        .req_type (req_type),
        .target_x (target_x),
        .target_y (target_y),
        .cfg      (cfg_reg),
        .item     (front_item)
    );

    tspm_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (in_valid),
        .push_stall (in_stall),
        .push_item  (front_item),
        .pop_valid  (head_valid),
        .pop        (head_pop),
        .pop_item   (head_item)
    );

    tspm_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .item_valid (head_valid),
        .item       (head_item),
        .pop        (head_pop),
        .res_valid  (out_valid),
        .res_stall  (out_stall),
        .res        (res)
    );

    // Unpack the result beat
    assign step_x   = res.step_x;
    assign dir_x    = res.dir_x;
    assign step_y   = res.step_y;
    assign dir_y    = res.dir_y;
    assign busy_res = res.busy;
    assign status   = res.status;

endmodule

FILE: tb/tb.sv
// ----------------------------------------------------------------------------
// Two-axis step pulse mover: block-level testbench
// Drives ticks and absolute moves through the valid/stall input channel and
// checks every result beat against a cycle-free predictor of the phase
// sequencer. Covers reset values, range and busy rejects, zero-length moves,
// limit writes wider than the field, half-period writes mid-pulse, then long
// random runs of short moves under random idling and one long output hold-off.
// ----------------------------------------------------------------------------
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int POS_W      = tspm_pkg::POS_W;
    localparam int HALF_W     = tspm_pkg::HALF_W;
    localparam int CFG_IDX_W  = tspm_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W = tspm_pkg::CFG_DATA_W;

    localparam int RANDOM_ITEMS = 1450;
    localparam int DRAIN_CYCLES = 6;
    localparam int LONG_HOLD    = 200;
    localparam int MAX_REPORTS  = 200;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;
    localparam logic [POS_W-1:0]     POS_TOP        = '1;

    // Predicts the sequencer and holds the result beats still to arrive
    class step_pulse_scoreboard;
        logic [HALF_W-1:0]  half_x;
        logic [HALF_W-1:0]  half_y;
        logic [POS_W-1:0]   max_pos;
        logic [POS_W-1:0]   pos_x;
        logic [POS_W-1:0]   pos_y;
        logic [POS_W-1:0]   left_x;
        logic [POS_W-1:0]   left_y;
        logic [HALF_W-1:0]  tick_count;
        logic [1:0]         dir_bits;
        tspm_pkg::phase_t   phase;
        tspm_pkg::result_t  awaited_results[$];
        int                 errors;
        int                 reports;

        function new();
            half_x     = tspm_pkg::HALF_X_RESET;
            half_y     = tspm_pkg::HALF_Y_RESET;
            max_pos    = tspm_pkg::MAX_POS_RESET;
            pos_x      = '0;
            pos_y      = '0;
            left_x     = '0;
            left_y     = '0;
            tick_count = '0;
            dir_bits   = '0;
            phase      = tspm_pkg::PH_IDLE;
            errors     = 0;
            reports    = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                tspm_pkg::CFG_HALF_X:  half_x = data;
                tspm_pkg::CFG_HALF_Y:  half_y = data;
                tspm_pkg::CFG_MAX_POS: max_pos = data[POS_W-1:0];
                default: ;
            endcase
        endfunction

        // A half period of zero counts as one tick
        function bit half_done(logic [HALF_W-1:0] half);
            logic [HALF_W:0] lim;
            lim = (half == '0) ? 17'd1 : {1'b0, half};
            return ({1'b0, tick_count} + 17'd1) >= lim;
        endfunction

        function void next_pulse();
            tick_count = '0;
            if (left_x != '0)
                phase = tspm_pkg::PH_XHI;
            else if (left_y != '0)
                phase = tspm_pkg::PH_YHI;
            else
                phase = tspm_pkg::PH_IDLE;
        endfunction

        function void advance_tick();
            case (phase)
                tspm_pkg::PH_XHI:
                    if (half_done(half_x))
                    begin
                        tick_count = '0;
                        phase = tspm_pkg::PH_XLO;
                    end
                    else
                        tick_count++;
                tspm_pkg::PH_XLO:
                    if (half_done(half_x))
                    begin
                        if (left_x != '0)
                            left_x--;
                        next_pulse();
                    end
                    else
                        tick_count++;
                tspm_pkg::PH_YHI:
                    if (half_done(half_y))
                    begin
                        tick_count = '0;
                        phase = tspm_pkg::PH_YLO;
                    end
                    else
                        tick_count++;
                tspm_pkg::PH_YLO:
                    if (half_done(half_y))
                    begin
                        if (left_y != '0)
                            left_y--;
                        next_pulse();
                    end
                    else
                        tick_count++;
                default:
                begin
                    phase = tspm_pkg::PH_IDLE;
                    tick_count = '0;
                end
            endcase
        endfunction

        // Update the prediction for one accepted input beat
        function void predict_item(logic is_move, logic [POS_W-1:0] tx, logic [POS_W-1:0] ty);
            tspm_pkg::result_t want;
            tspm_pkg::phase_t  shown;
            want.status = tspm_pkg::ST_TICK;
            if (is_move)
            begin
                if (phase != tspm_pkg::PH_IDLE)
                    want.status = tspm_pkg::ST_BUSY;
                else if (tx > max_pos || ty > max_pos)
                    want.status = tspm_pkg::ST_RANGE;
                else
                begin
                    want.status = tspm_pkg::ST_ACCEPT;
                    dir_bits = {ty <= pos_y, tx <= pos_x};
                    left_x = (tx > pos_x) ? tx - pos_x : pos_x - tx;
                    left_y = (ty > pos_y) ? ty - pos_y : pos_y - ty;
                    pos_x = tx;
                    pos_y = ty;
                    next_pulse();
                end
                shown = phase;
            end
            else
            begin
                shown = phase;
                advance_tick();
            end
            want.step_x = (shown == tspm_pkg::PH_XHI);
            want.dir_x  = dir_bits[0];
            want.step_y = (shown == tspm_pkg::PH_YHI);
            want.dir_y  = dir_bits[1];
            want.busy   = (phase != tspm_pkg::PH_IDLE);
            awaited_results.push_back(want);
        endfunction

        function void compare_field(string field, logic [1:0] want, logic [1:0] got);
            if (want !== got)
            begin
                errors++;
                reports++;
                if (reports <= MAX_REPORTS)
                    $display("%0t: %s mismatch, expected %0d, actual %0d",
                             $time, field, want, got);
            end
        endfunction

        // Match one output beat against the oldest awaited result
        function void check_result(tspm_pkg::result_t got);
            tspm_pkg::result_t want;
            if (awaited_results.size() == 0)
            begin
                errors++;
                reports++;
                if (reports <= MAX_REPORTS)
                    $display("%0t: unexpected result beat, expected none, actual %h",
                             $time, got);
                return;
            end
            want = awaited_results.pop_front();
            compare_field("step_x", 2'(want.step_x), 2'(got.step_x));
            compare_field("dir_x", 2'(want.dir_x), 2'(got.dir_x));
            compare_field("step_y", 2'(want.step_y), 2'(got.step_y));
            compare_field("dir_y", 2'(want.dir_y), 2'(got.dir_y));
            compare_field("busy_res", 2'(want.busy), 2'(got.busy));
            compare_field("status", want.status, got.status);
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  in_valid;
    logic                  in_stall;
    logic                  req_type;
    logic [POS_W-1:0]      target_x;
    logic [POS_W-1:0]      target_y;
    logic                  out_valid;
    logic                  out_stall;
    logic                  step_x;
    logic                  dir_x;
    logic                  step_y;
    logic                  dir_y;
    logic                  busy_res;
    logic [1:0]            status;

    step_pulse_scoreboard sb = new();

    int send_gap_max = 7;
    int recv_gap_max = 7;
    bit long_hold_req = 1'b0;

    two_axis_step_pulse_mover_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_idx   (cfg_idx),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .req_type  (req_type),
        .target_x  (target_x),
        .target_y  (target_y),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .step_x    (step_x),
        .dir_x     (dir_x),
        .step_y    (step_y),
        .dir_y     (dir_y),
        .busy_res  (busy_res),
        .status    (status)
    );

    always #2 clk = ~clk;

    // Check each accepted output beat
    always @(posedge clk)
    begin
        tspm_pkg::result_t got;
        if (rst_n && out_valid && !out_stall)
        begin
            got.step_x = step_x;
            got.dir_x  = dir_x;
            got.step_y = step_y;
            got.dir_y  = dir_y;
            got.busy   = busy_res;
            got.status = tspm_pkg::status_t'(status);
            sb.check_result(got);
        end
    end

    // Receiver: stall a random number of cycles before each beat
    initial
    begin
        int hold;
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                hold = LONG_HOLD;
            end
            else
                hold = $urandom_range(0, recv_gap_max);
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
        end
    end

    // Offer one input beat after a random gap and hold it until accepted
    task automatic send_item(input logic is_move, input logic [POS_W-1:0] tx,
                             input logic [POS_W-1:0] ty);
        int gap;
        gap = $urandom_range(0, send_gap_max);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        req_type <= is_move;
        target_x <= tx;
        target_y <= ty;
        do @(posedge clk); while (in_stall);
        sb.predict_item(is_move, tx, ty);
    endtask

    task automatic send_tick();
        send_item(1'b0, POS_W'($urandom), POS_W'($urandom));
    endtask

    // Tick until the current move has emitted all its pulses
    task automatic tick_until_idle();
        while (sb.phase != tspm_pkg::PH_IDLE)
            send_tick();
    endtask

    // Let every awaited beat come out before touching the registers
    task automatic drain();
        in_valid <= 1'b0;
        while (sb.awaited_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= data;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
        sb.write_reg(idx, data);
    endtask

    task automatic set_idling(input int send_max, input int recv_max);
        send_gap_max = send_max;
        recv_gap_max = recv_max;
    endtask

    // Main sequence
    initial
    begin
        int sent;
        int phase_no;
        int phase_len;
        int pick;
        int hi;
        int lim;
        int tx;
        int ty;

        clk       = 1'b0;
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_idx   = '0;
        cfg_wdata = '0;
        in_valid  = 1'b0;
        req_type  = 1'b0;
        target_x  = '0;
        target_y  = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Reset values: idle tick, range rejects at the default limit
        send_item(1'b0, POS_TOP, POS_TOP);
        send_item(1'b1, 14'd5001, 14'd0);
        send_item(1'b1, 14'd0, 14'd5001);
        // Zero-length move sets both directions and stays idle
        send_item(1'b1, 14'd0, 14'd0);
        // One step per axis at the default half periods, then a busy reject
        send_item(1'b1, 14'd1, 14'd1);
        send_item(1'b1, POS_TOP, POS_TOP);
        set_idling(0, 0);
        repeat (4) send_tick();
        drain();
        // Shorten both half periods inside the first high half
        write_reg(tspm_pkg::CFG_HALF_X, 16'd2);
        write_reg(tspm_pkg::CFG_HALF_Y, 16'd3);
        tick_until_idle();
        drain();

        // Zero half period, ignored register index, limit wider than its field
        write_reg(tspm_pkg::CFG_HALF_X, 16'd0);
        write_reg(tspm_pkg::CFG_HALF_Y, 16'd1);
        write_reg(CFG_UNUSED_IDX, 16'hFFFF);
        write_reg(tspm_pkg::CFG_MAX_POS, 16'hFFFF);
        send_item(1'b1, 14'd12, 14'd1);
        tick_until_idle();
        send_item(1'b1, 14'd0, 14'd0);
        tick_until_idle();
        drain();
        set_idling(7, 7);

        // Limit of zero: only the origin is reachable
        write_reg(tspm_pkg::CFG_MAX_POS, 16'd0);
        send_item(1'b1, 14'd0, 14'd0);
        send_item(1'b1, 14'd1, 14'd0);
        send_item(1'b1, 14'd0, 14'd1);
        send_tick();
        drain();

        // Lower the half periods in the middle of a long high half
        write_reg(tspm_pkg::CFG_MAX_POS, 16'd100);
        write_reg(tspm_pkg::CFG_HALF_X, 16'hFFFF);
        write_reg(tspm_pkg::CFG_HALF_Y, 16'hFFFF);
        send_item(1'b1, 14'd2, 14'd1);
        repeat (3) send_tick();
        drain();
        write_reg(tspm_pkg::CFG_HALF_X, 16'd1);
        write_reg(tspm_pkg::CFG_HALF_Y, 16'd0);
        tick_until_idle();

        // Random phases of short moves with fresh settings each time
        sent = 0;
        phase_no = 0;
        while (sent < RANDOM_ITEMS)
        begin
            drain();
            hi = (sb.pos_x > sb.pos_y) ? int'(sb.pos_x) : int'(sb.pos_y);
            lim = ($urandom_range(0, 3) == 0) ? hi : hi + $urandom_range(2, 40);
            if (lim > int'(POS_TOP))
                lim = int'(POS_TOP);
            write_reg(tspm_pkg::CFG_MAX_POS, CFG_DATA_W'(lim));
            write_reg(tspm_pkg::CFG_HALF_X, ($urandom_range(0, 4) == 0) ?
                      CFG_DATA_W'($urandom_range(4, 9)) : CFG_DATA_W'($urandom_range(0, 3)));
            write_reg(tspm_pkg::CFG_HALF_Y, ($urandom_range(0, 4) == 0) ?
                      CFG_DATA_W'($urandom_range(4, 9)) : CFG_DATA_W'($urandom_range(0, 3)));
            if ($urandom_range(0, 3) == 0)
                write_reg(CFG_UNUSED_IDX, CFG_DATA_W'($urandom));

            // Pick idling for this phase; once, hold the output off for long
            case ($urandom_range(0, 3))
                0: set_idling(7, 7);
                1: set_idling(0, 0);
                2: set_idling(0, 7);
                default: set_idling(7, 0);
            endcase
            if (phase_no == 2)
            begin
                set_idling(0, 3);
                long_hold_req = 1'b1;
            end

            phase_len = $urandom_range(60, 160);
            for (int i = 0; i < phase_len; i++)
            begin
                pick = $urandom_range(0, 99);
                if (sb.phase != tspm_pkg::PH_IDLE)
                begin
                    // Mostly ticks; the odd move gets a busy reject
                    if (pick < 92)
                        send_tick();
                    else
                        send_item(1'b1, POS_W'($urandom), POS_W'($urandom));
                end
                else if (pick < 62)
                begin
                    // Short well-formed move around the current position
                    tx = int'(sb.pos_x) + int'($urandom_range(0, 6)) - 3;
                    ty = int'(sb.pos_y) + int'($urandom_range(0, 6)) - 3;
                    tx = (tx < 0) ? 0 : (tx > int'(sb.max_pos)) ? int'(sb.max_pos) : tx;
                    ty = (ty < 0) ? 0 : (ty > int'(sb.max_pos)) ? int'(sb.max_pos) : ty;
                    send_item(1'b1, POS_W'(tx), POS_W'(ty));
                end
                else if (pick < 76 && sb.max_pos != POS_TOP)
                begin
                    // Target beyond the limit on one or both axes
                    tx = $urandom_range(int'(sb.max_pos) + 1, int'(POS_TOP));
                    ty = ($urandom_range(0, 1) == 0) ? int'(sb.pos_y) :
                         $urandom_range(int'(sb.max_pos) + 1, int'(POS_TOP));
                    if ($urandom_range(0, 1) == 0)
                        send_item(1'b1, POS_W'(tx), POS_W'(ty));
                    else
                        send_item(1'b1, POS_W'(ty), POS_W'(tx));
                end
                else
                    send_tick();
                sent++;
            end
            phase_no++;
        end

        drain();
        if (sb.errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // Hard stop if the run hangs
    initial
    begin
        #4_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
